FILE: rtl/awr_pkg.sv
// Shared constants, binomial tables and stage payload types for the ascending word rank block.
package awr_pkg;

  localparam int MAX_LEN     = 6;
  localparam int ALPHABET    = 26;
  localparam int CHAR_FIELDS = 6;
  localparam int LEN_W       = 3;
  localparam int CHAR_W      = 8;
  localparam int RANK_W      = 19;
  localparam int LET_W       = $clog2(ALPHABET);
  localparam int N_W         = $clog2(ALPHABET + 1);
  localparam int K_W         = $clog2(MAX_LEN + 1);

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;

  typedef logic [RANK_W-1:0] rank_t;
  typedef rank_t [MAX_LEN:0] binom_row_t;
  typedef binom_row_t [ALPHABET:0] binom_tab_t;
  typedef rank_t [MAX_LEN:0] offset_tab_t;

  // Pascal's triangle, C(n,k) for n up to ALPHABET and k up to MAX_LEN
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n <= ALPHABET; n++) begin
      t[n][0] = rank_t'(1);
      for (int k = 1; k <= MAX_LEN; k++) begin
        if (n > 0) begin
          t[n][k] = t[n-1][k-1] + t[n-1][k];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

  // Number of words shorter than a given length
  function automatic offset_tab_t build_offset();
    offset_tab_t o;
    o = '0;
    for (int l = 2; l <= MAX_LEN; l++) begin
      o[l] = o[l-1] + BINOM[ALPHABET][l-1];
    end
    return o;
  endfunction

  localparam offset_tab_t OFFSET = build_offset();

  function automatic rank_t build_not_found();
    rank_t s;
    s = rank_t'(1);
    for (int k = 1; k <= MAX_LEN; k++) begin
      s = s + BINOM[ALPHABET][k];
    end
    return s;
  endfunction

  localparam rank_t NOT_FOUND = build_not_found();

  typedef struct packed {
    logic                              ok;
    logic [LEN_W-1:0]                  len;
    logic [CHAR_FIELDS-1:0][LET_W-1:0] letter;
  } dec_t;

  typedef struct packed {
    logic                    ok;
    rank_t                   offset;
    rank_t [CHAR_FIELDS-1:0] term;
  } term_t;

  typedef struct packed {
    logic        ok;
    rank_t [2:0] part;
  } part_t;

endpackage

FILE: rtl/awr_decode.sv
// Stage one: letter extraction and word validity checks.
module awr_decode (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic [awr_pkg::LEN_W-1:0]                        word_length,
  input  logic [awr_pkg::CHAR_FIELDS-1:0][awr_pkg::CHAR_W-1:0] chars,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output awr_pkg::dec_t                                    out_data
);

  awr_pkg::dec_t dec_next;

  always_comb begin
    logic [awr_pkg::CHAR_W-1:0] diff;
    logic                       used;
    logic                       in_rng;
    dec_next     = '0;
    dec_next.len = word_length;
    dec_next.ok  = (word_length != '0)
                && ({1'b0, word_length} <= (awr_pkg::LEN_W+1)'(awr_pkg::MAX_LEN))
                && ({1'b0, word_length} <= (awr_pkg::LEN_W+1)'(awr_pkg::CHAR_FIELDS));
    for (int i = 0; i < awr_pkg::CHAR_FIELDS; i++) begin
      diff   = chars[i] - awr_pkg::CHAR_A;
      used   = (awr_pkg::LEN_W+1)'(i) < {1'b0, word_length};
      in_rng = ({1'b0, chars[i]} >= {1'b0, awr_pkg::CHAR_A})
            && ({1'b0, chars[i]} < ({1'b0, awr_pkg::CHAR_A}
                                    + (awr_pkg::CHAR_W+1)'(awr_pkg::ALPHABET)));
      dec_next.letter[i] = diff[awr_pkg::LET_W-1:0];
      if (used && !in_rng) begin
        dec_next.ok = 1'b0;
      end
      // strictly ascending: compare raw bytes; an out-of-range byte clears ok anyway
      if (i > 0 && used && chars[i] <= chars[i-1]) begin
        dec_next.ok = 1'b0;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= dec_next;
    end
  end

endmodule

FILE: rtl/awr_term.sv
// Stage two: per-position binomial table lookups and length offset.
module awr_term (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  awr_pkg::dec_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output awr_pkg::term_t out_data
);

  awr_pkg::term_t term_next;

  // Words skipped at one position collapse to C(26-prev, k) - C(26-letter, k)
  always_comb begin
    logic [awr_pkg::LEN_W:0]   kk;
    logic [awr_pkg::N_W-1:0]   prev;
    logic [awr_pkg::N_W-1:0]   n_a;
    logic [awr_pkg::N_W-1:0]   n_b;
    logic                      used;
    term_next    = '0;
    term_next.ok = in_data.ok;
    if (in_data.ok) begin
      term_next.offset = awr_pkg::OFFSET[awr_pkg::K_W'(in_data.len)];
    end
    for (int i = 0; i < awr_pkg::CHAR_FIELDS; i++) begin
      kk   = {1'b0, in_data.len} - (awr_pkg::LEN_W+1)'(i);
      used = (awr_pkg::LEN_W+1)'(i) < {1'b0, in_data.len};
      if (i == 0) begin
        prev = '0;
      end else begin
        prev = awr_pkg::N_W'(in_data.letter[i-1]) + awr_pkg::N_W'(1);
      end
      n_a = awr_pkg::N_W'(awr_pkg::ALPHABET) - prev;
      n_b = awr_pkg::N_W'(awr_pkg::ALPHABET) - awr_pkg::N_W'(in_data.letter[i]);
      if (in_data.ok && used && kk <= (awr_pkg::LEN_W+1)'(awr_pkg::MAX_LEN)) begin
        term_next.term[i] = awr_pkg::BINOM[n_a][kk[awr_pkg::K_W-1:0]]
                          - awr_pkg::BINOM[n_b][kk[awr_pkg::K_W-1:0]];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= term_next;
    end
  end

endmodule

FILE: rtl/awr_accum.sv
// Stages three and four: adder tree and output register with not-found select.
module awr_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  awr_pkg::term_t        in_data,
  output logic                  part_valid,
  output logic                  out_valid,
  input  logic                  out_ready,
  output awr_pkg::rank_t        word_rank,
  output logic                  word_found
);

  awr_pkg::part_t part;
  awr_pkg::part_t part_next;
  awr_pkg::rank_t rank_next;
  logic           part_ready;

  always_comb begin
    part_next.ok      = in_data.ok;
    part_next.part[0] = in_data.term[0] + in_data.term[1];
    part_next.part[1] = in_data.term[2] + in_data.term[3];
    part_next.part[2] = in_data.term[4] + in_data.term[5] + in_data.offset;
  end

  always_comb begin
    if (part.ok) begin
      rank_next = part.part[0] + part.part[1] + part.part[2] + awr_pkg::rank_t'(1);
    end else begin
      rank_next = awr_pkg::NOT_FOUND;
    end
  end

  assign part_ready = !out_valid || out_ready;
  assign in_ready   = !part_valid || part_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        part_valid <= in_valid;
      end
      if (part_ready) begin
        out_valid <= part_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      part <= part_next;
    end
    if (part_ready && part_valid) begin
      word_rank  <= rank_next;
      word_found <= part.ok;
    end
  end

endmodule

FILE: rtl/ascending_word_rank_top.sv
// Top level of the ascending word rank block: stream ports, stage chain and checks.
// Gives the 1-based rank of a word among all strictly ascending lowercase words of
// length 1 to 6, shorter words first and then in dictionary order; a word that is
// empty, too long, holds a non-letter or does not ascend gets rank 313912 with the
// found flag clear. One word is accepted every clock cycle while any stage is empty or
// the output takes a result. It passes through four register stages: decode and checks,
// binomial table lookup, a first adder level, and the final sum in the output register.
// Each stage holds its item only while the next one is full, so empty slots are closed
// up when the output side stalls.
module ascending_word_rank_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // word_length[2:0], char_1..char_6 [50:3], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // word_rank[18:0], word_found[19], zero pad
);

  logic [awr_pkg::CHAR_FIELDS-1:0][awr_pkg::CHAR_W-1:0] chars;
  awr_pkg::dec_t  dec_data;
  awr_pkg::term_t term_data;
  awr_pkg::rank_t word_rank;
  logic           word_found;
  logic           dec_valid;
  logic           dec_ready;
  logic           term_valid;
  logic           term_ready;
  logic           part_valid;

  always_comb begin
    for (int i = 0; i < awr_pkg::CHAR_FIELDS; i++) begin
      chars[i] = s_tdata[awr_pkg::LEN_W + i*awr_pkg::CHAR_W +: awr_pkg::CHAR_W];
    end
  end

  awr_decode u_dec (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .word_length (s_tdata[awr_pkg::LEN_W-1:0]),
    .chars       (chars),
    .out_valid   (dec_valid),
    .out_ready   (dec_ready),
    .out_data    (dec_data)
  );

  awr_term u_term (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_data  (term_data)
  );

  awr_accum u_acc (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (term_valid),
    .in_ready   (term_ready),
    .in_data    (term_data),
    .part_valid (part_valid),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .word_rank  (word_rank),
    .word_found (word_found)
  );

  assign m_tdata = {4'b0000, word_found, word_rank};

  // a rejected word always carries the not-found rank
  a_not_found_rank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[19] |-> m_tdata[18:0] == awr_pkg::NOT_FOUND)
    else $error("rejected word without not-found rank");

  a_found_rank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19] |-> m_tdata[18:0] != awr_pkg::NOT_FOUND
                             && m_tdata[18:0] != '0)
    else $error("found word with out-of-list rank");

  // input back-pressure only when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> dec_valid && term_valid && part_valid && m_tvalid)
    else $error("input stalled with an empty stage");

  a_dec_len: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_data.ok |-> dec_data.len != '0
      && {1'b0, dec_data.len} <= (awr_pkg::LEN_W+1)'(awr_pkg::MAX_LEN))
    else $error("accepted word with bad length");

endmodule
